// ===== src/mhpq_pkg.sv =====
// shared types and constants for the max-heap priority queue
// no dependencies

package mhpq_pkg;

	localparam int HEAP_DEPTH = 1024;
	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int DW = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		RD_PARENT,
		RD_REMOVE,
		RD_KIDS
	} rd_kind_t;

	typedef enum logic [1:0] {
		WR_VAL,
		WR_PARENT,
		WR_BEST
	} wr_kind_t;

	typedef struct packed {
		logic     load;
		logic     inc_cnt;
		logic     rd_en;
		rd_kind_t rd_kind;
		logic     take_rem;
		logic     wr_en;
		wr_kind_t wr_kind;
		logic     up_step;
		logic     down_step;
		logic     publish;
		logic     err;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic rem_bad;
		logic pos_zero;
		logic pos_last;
		logic up_gt;
		logic down_any;
	} sts_t;

endpackage

// ===== src/max_heap_priority_queue.sv =====
// binary max-heap priority queue of signed 32-bit values, 1024 entries
// a refused item goes straight to the result; an insert climbs from the new last slot;
// a removal reads the entry and the last one and ends there when the last entry goes, else
// the last entry fills the hole and climbs past smaller parents, or walks down if it cannot
// one item at a time, the next accepted the cycle after the result is registered
// reset: arst_n clears the entry count and handshake state; the memory is not cleared
// depends on mhpq_pkg, mhpq_ctrl, mhpq_datapath

module max_heap_priority_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             opcode,
	input  logic signed [mhpq_pkg::DW-1:0]   insert_value,
	input  logic        [mhpq_pkg::AW-1:0]   remove_position,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [mhpq_pkg::DW-1:0]   removed_value,
	output logic signed [mhpq_pkg::DW-1:0]   max_value,
	output logic        [mhpq_pkg::CW-1:0]   entry_count,
	output logic                             is_empty,
	output logic                             op_error
);
	import mhpq_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: takes an item only when idle, holds the finished item
	// until the output register is free
	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: heap memory, hole-based sift, root shadow, result registers
	mhpq_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.opcode          (opcode),
		.insert_value    (insert_value),
		.remove_position (remove_position),
		.removed_value   (removed_value),
		.max_value       (max_value),
		.entry_count     (entry_count),
		.is_empty        (is_empty),
		.op_error        (op_error)
	);

`ifndef SYNTHESIS
	// a refused item never reports a removed value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_error |-> removed_value == '0)
		else $error("error item carries a removed value");

	// empty flag and count agree, and an empty heap shows no maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == '0)) && (!is_empty || max_value == '0))
		else $error("empty flag out of step with count");

	// count never exceeds the heap depth
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CW'(HEAP_DEPTH))
		else $error("entry count beyond depth");
`endif

endmodule

// ===== src/mhpq_datapath.sv =====
// heap memory, count, moving value and result registers
// depends on mhpq_pkg

module mhpq_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mhpq_pkg::cmd_t                   cmd,
	output mhpq_pkg::sts_t                   sts,
	input  logic                             opcode,
	input  logic signed [mhpq_pkg::DW-1:0]   insert_value,
	input  logic        [mhpq_pkg::AW-1:0]   remove_position,
	output logic signed [mhpq_pkg::DW-1:0]   removed_value,
	output logic signed [mhpq_pkg::DW-1:0]   max_value,
	output logic        [mhpq_pkg::CW-1:0]   entry_count,
	output logic                             is_empty,
	output logic                             op_error
);
	import mhpq_pkg::*;

	logic signed [DW-1:0] mem_q [HEAP_DEPTH];
	logic signed [DW-1:0] rd_a_q, rd_b_q;
	logic signed [DW-1:0] val_q, removed_q, root_q;
	logic        [AW-1:0] pos_q;
	logic        [CW-1:0] cnt_q;

	logic        [AW-1:0] parent_idx, rd_a_addr, rd_b_addr, best_idx, last_idx;
	logic        [CW:0]   left_w, right_w;
	logic                 left_ok, right_ok, left_gt, right_gt;
	logic signed [DW-1:0] left_ref, best_val, wr_data;

	assign parent_idx = AW'((pos_q - AW'(1)) >> 1);
	assign left_w     = {1'b0, pos_q, 1'b1};
	assign right_w    = left_w + (CW+1)'(1);
	assign left_ok    = left_w < {1'b0, cnt_q};
	assign right_ok   = right_w < {1'b0, cnt_q};
	assign left_gt    = left_ok && (rd_a_q > val_q);
	assign left_ref   = left_gt ? rd_a_q : val_q;
	assign right_gt   = right_ok && (rd_b_q > left_ref);
	assign best_idx   = right_gt ? right_w[AW-1:0] : left_w[AW-1:0];
	assign best_val   = right_gt ? rd_b_q : rd_a_q;
	assign last_idx   = AW'(cnt_q - CW'(1));

	always_comb begin
		unique case (cmd.rd_kind)
			RD_PARENT: begin
				rd_a_addr = parent_idx;
				rd_b_addr = last_idx;
			end
			RD_KIDS: begin
				rd_a_addr = left_w[AW-1:0];
				rd_b_addr = right_w[AW-1:0];
			end
			default: begin
				rd_a_addr = pos_q;
				rd_b_addr = last_idx;
			end
		endcase
		unique case (cmd.wr_kind)
			WR_PARENT: wr_data = rd_a_q;
			WR_BEST:   wr_data = best_val;
			default:   wr_data = val_q;
		endcase
	end

	always_comb begin
		sts.full     = cnt_q == CW'(HEAP_DEPTH);
		sts.rem_bad  = {1'b0, remove_position} >= cnt_q;
		sts.pos_zero = pos_q == '0;
		sts.pos_last = {1'b0, pos_q} == CW'(cnt_q - CW'(1));
		sts.up_gt    = val_q > rd_a_q;
		sts.down_any = left_gt || right_gt;
	end

	// heap memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[pos_q] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_a_q <= mem_q[rd_a_addr];
			rd_b_q <= mem_q[rd_b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.inc_cnt) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.take_rem) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			removed_q <= '0;
			val_q     <= insert_value;
			pos_q     <= (opcode == OP_REMOVE) ? remove_position : cnt_q[AW-1:0];
		end
		if (cmd.take_rem) begin
			removed_q <= rd_a_q;
			val_q     <= rd_b_q;
		end
		if (cmd.up_step) begin
			pos_q <= parent_idx;
		end
		if (cmd.down_step) begin
			pos_q <= best_idx;
		end
		// shadow of the root entry
		if (cmd.wr_en && pos_q == '0) begin
			root_q <= wr_data;
		end
		if (cmd.publish) begin
			removed_value <= cmd.err ? '0 : removed_q;
			max_value     <= (cnt_q == '0) ? '0 : root_q;
			entry_count   <= cnt_q;
			is_empty      <= cnt_q == '0;
			op_error      <= cmd.err;
		end
	end

endmodule

// ===== src/mhpq_ctrl.sv =====
// sequencer for insert, removal and the sift walks
// depends on mhpq_pkg

module mhpq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           opcode,
	output logic           out_valid,
	input  logic           out_ready,
	input  mhpq_pkg::sts_t sts,
	output mhpq_pkg::cmd_t cmd
);
	import mhpq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_REM,
		S_TAKE,
		S_RD_UP,
		S_CMP_UP,
		S_RD_DN,
		S_CMP_DN,
		S_FIN
	} state_t;

	state_t state_q;
	logic   err_q, first_q, out_valid_q;
	logic   accept, bad;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign bad       = (opcode == OP_INSERT) ? sts.full : sts.rem_bad;

	always_comb begin
		cmd         = '0;
		cmd.rd_kind = RD_PARENT;
		cmd.wr_kind = WR_VAL;
		cmd.err     = err_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load    = accept && !bad;
				cmd.inc_cnt = accept && !bad && opcode == OP_INSERT;
			end
			S_RD_REM: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_kind = RD_REMOVE;
			end
			S_TAKE: cmd.take_rem = 1'b1;
			S_RD_UP: begin
				cmd.rd_en = !sts.pos_zero;
				cmd.wr_en = sts.pos_zero && !first_q;
			end
			S_CMP_UP: begin
				cmd.up_step = sts.up_gt;
				cmd.wr_en   = sts.up_gt || !first_q;
				cmd.wr_kind = sts.up_gt ? WR_PARENT : WR_VAL;
			end
			S_RD_DN: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_kind = RD_KIDS;
			end
			S_CMP_DN: begin
				cmd.down_step = sts.down_any;
				cmd.wr_en     = 1'b1;
				cmd.wr_kind   = sts.down_any ? WR_BEST : WR_VAL;
			end
			S_FIN: cmd.publish = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			err_q       <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						err_q   <= bad;
						first_q <= 1'b0;
						if (bad) begin
							state_q <= S_FIN;
						end else if (opcode == OP_INSERT) begin
							state_q <= S_RD_UP;
						end else begin
							state_q <= S_RD_REM;
						end
					end
				end
				S_RD_REM: state_q <= S_TAKE;
				S_TAKE: begin
					first_q <= 1'b1;
					state_q <= sts.pos_last ? S_FIN : S_RD_UP;
				end
				S_RD_UP: begin
					if (!sts.pos_zero) begin
						state_q <= S_CMP_UP;
					end else if (first_q) begin
						state_q <= S_RD_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_CMP_UP: begin
					if (sts.up_gt) begin
						first_q <= 1'b0;
						state_q <= S_RD_UP;
					end else if (first_q) begin
						state_q <= S_RD_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_RD_DN: state_q <= S_CMP_DN;
				S_CMP_DN: state_q <= sts.down_any ? S_RD_DN : S_FIN;
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for max_heap_priority_queue
// predicts every result with its own heap copy; depends on mhpq_pkg and the block's rtl
`timescale 1ns / 100ps

module tb;
	import mhpq_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic           op;
		logic [DW-1:0]  val;
		logic [AW-1:0]  pos;
	} heap_item_t;

	typedef struct {
		logic [DW-1:0]  removed;
		logic [DW-1:0]  maxv;
		logic [CW-1:0]  count;
		logic           empty;
		logic           err;
	} heap_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = OP_INSERT;
	logic signed [DW-1:0] insert_value = '0;
	logic [AW-1:0] remove_position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DW-1:0] removed_value;
	logic signed [DW-1:0] max_value;
	logic [CW-1:0] entry_count;
	logic is_empty;
	logic op_error;

	max_heap_priority_queue dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow heap, updated as items are accepted
	logic signed [DW-1:0] shadow_heap [HEAP_DEPTH];
	int shadow_count = 0;

	heap_item_t pending_items[$];
	heap_result_t expected_results[$];
	int errors = 0;
	int inserts_done = 0, removes_done = 0, refusals_seen = 0;
	bit idle_free = 1'b0;
	// receiver stall: requested by the stimulus, counted by the receiver
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	int hold_cycles = 0;

	function automatic int sift_up(int p);
		logic signed [DW-1:0] t;
		int up;
		while (p > 0) begin
			up = (p - 1) / 2;
			if (shadow_heap[p] > shadow_heap[up]) begin
				t = shadow_heap[p]; shadow_heap[p] = shadow_heap[up]; shadow_heap[up] = t;
				p = up;
			end else
				break;
		end
		return p;
	endfunction

	function automatic void sift_down(int p);
		logic signed [DW-1:0] t;
		int l, r, best;
		while (p < shadow_count) begin
			l = 2 * p + 1;
			r = l + 1;
			best = p;
			if (l < shadow_count && shadow_heap[l] > shadow_heap[best]) best = l;
			if (r < shadow_count && shadow_heap[r] > shadow_heap[best]) best = r;
			if (best == p) break;
			t = shadow_heap[p]; shadow_heap[p] = shadow_heap[best]; shadow_heap[best] = t;
			p = best;
		end
	endfunction

	function automatic heap_result_t predict_heap_op(heap_item_t it);
		heap_result_t r;
		int p;
		r.removed = '0;
		r.err = 1'b0;
		if (it.op == OP_INSERT) begin
			if (shadow_count >= HEAP_DEPTH)
				r.err = 1'b1;
			else begin
				shadow_heap[shadow_count] = it.val;
				void'(sift_up(shadow_count));
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0 || int'(it.pos) >= shadow_count)
				r.err = 1'b1;
			else begin
				r.removed = shadow_heap[it.pos];
				shadow_heap[it.pos] = shadow_heap[shadow_count - 1];
				shadow_count--;
				if (int'(it.pos) < shadow_count) begin
					p = sift_up(it.pos);
					if (p == int'(it.pos)) sift_down(it.pos);
				end
			end
		end
		r.maxv = shadow_count != 0 ? shadow_heap[0] : '0;
		r.count = shadow_count[CW-1:0];
		r.empty = shadow_count == 0;
		return r;
	endfunction

	// driver: offers the next pending item, idles now and then
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_heap_op(pending_items.pop_front()));
				if (opcode == OP_INSERT) inserts_done++; else removes_done++;
			end
			if (!(in_valid && !in_ready)) begin
				// the item just taken has been popped; decide on the next one
				if (pending_items.size() != 0 && (idle_free || $urandom_range(99) >= 11)) begin
					in_valid <= 1'b1;
					opcode <= pending_items[0].op;
					insert_value <= pending_items[0].val;
					remove_position <= pending_items[0].pos;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor: compares each result with the oldest expectation
	always @(posedge clk) begin
		heap_result_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result count=%0d", $time, entry_count);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (op_error) refusals_seen++;
					if (removed_value !== e.removed || max_value !== e.maxv ||
					    entry_count !== e.count || is_empty !== e.empty ||
					    op_error !== e.err) begin
						$display("%0t: expected rem=%0d max=%0d cnt=%0d emp=%0b err=%0b",
							$time, $signed(e.removed), $signed(e.maxv), e.count,
							e.empty, e.err);
						$display("%0t: actual   rem=%0d max=%0d cnt=%0d emp=%0b err=%0b",
							$time, removed_value, max_value, entry_count, is_empty,
							op_error);
						errors++;
					end
				end
			end
			// long stall of the receiver, counted here
			if (hold_go && !hold_done) begin
				if (hold_cycles >= HOLD_CYCLES)
					hold_done <= 1'b1;
				else
					hold_cycles <= hold_cycles + 1;
			end
			out_ready <= !(hold_go && !hold_done) && (idle_free || $urandom_range(99) >= 11);
		end
	end

	// watchdog on cycles with no accepted item, no taken result and no receiver stall
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (hold_go && !hold_done))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("end of test: mismatches");
			$finish;
		end
	end

	// items are queued with the count they will see, to keep positions mostly valid
	int plan_count = 0;

	task automatic queue_insert(logic [DW-1:0] v);
		heap_item_t it;
		it.op = OP_INSERT; it.val = v; it.pos = AW'($urandom);
		pending_items.push_back(it);
		if (plan_count < HEAP_DEPTH) plan_count++;
	endtask

	task automatic queue_remove(int p);
		heap_item_t it;
		it.op = OP_REMOVE; it.val = $urandom; it.pos = p[AW-1:0];
		pending_items.push_back(it);
		if (plan_count > 0 && p < plan_count) plan_count--;
	endtask

	task automatic drain_all();
		while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	function automatic logic [DW-1:0] random_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($urandom_range(7));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: removals on an empty heap, extremes, ties, last entry
		queue_remove(0);
		queue_remove(1023);
		queue_insert(32'h8000_0000);
		queue_insert(32'h7fff_ffff);
		queue_insert(32'h0000_0005);
		queue_insert(32'h0000_0005);
		queue_insert(32'hffff_ffff);
		queue_insert(32'h0000_0005);
		queue_remove(5);
		queue_remove(3);
		queue_remove(4);
		queue_remove(0);
		queue_remove(1);
		queue_remove(0);
		queue_remove(0);
		queue_remove(0);
		drain_all();

		// fill to the brim, then an insert when full, then stall the receiver
		idle_free = 1'b1;
		while (plan_count < HEAP_DEPTH) queue_insert(random_value());
		queue_insert(32'h1234_5678);
		hold_go = 1'b1;
		wait (hold_done);
		drain_all();
		idle_free = 1'b0;
		// shrink by random positions, then one removal most likely past the count
		while (plan_count > 500)
			queue_remove($urandom_range(3) == 0 ? 0 : $urandom_range(plan_count - 1));
		queue_remove($urandom_range(1023));
		drain_all();

		// random mix, mostly removals on the large heap left over
		repeat (140) begin
			if ($urandom_range(99) < 8)
				queue_remove($urandom_range(1023));
			else if (plan_count < 40 && $urandom_range(1))
				queue_insert(random_value());
			else if (plan_count > 0)
				queue_remove($urandom_range(1) ? 0 : $urandom_range(plan_count - 1));
			else
				queue_insert(random_value());
		end
		drain_all();
		repeat (50) @(posedge clk);

		$display("covered %0d inserts and %0d removals, %0d refused, full and empty heaps",
			inserts_done, removes_done, refusals_seen);
		if (errors == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
